// File: src/usip_pkg.sv
// ----------------------------------------------------------------------------
// usip_pkg
// Types, constants and codes shared by the UAS status IU parser modules.
// ----------------------------------------------------------------------------
package usip_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned SLEN_W   = 16;
  localparam int unsigned ERR_W    = 3;
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned SENSE_N  = 6;

  localparam int unsigned IU_MAX_BYTES_DEF = 4096;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // IU identifiers
  localparam logic [BYTE_W-1:0] IU_ID_SENSE       = 8'h03;
  localparam logic [BYTE_W-1:0] IU_ID_RESPONSE    = 8'h04;
  localparam logic [BYTE_W-1:0] IU_ID_READ_READY  = 8'h06;
  localparam logic [BYTE_W-1:0] IU_ID_WRITE_READY = 8'h07;

  // Sense response codes (bit 7 masked off)
  localparam logic [6:0] RC_FIXED_CUR  = 7'h70;
  localparam logic [6:0] RC_FIXED_DEF  = 7'h71;
  localparam logic [6:0] RC_DESC_CUR   = 7'h72;
  localparam logic [6:0] RC_DESC_DEF   = 7'h73;

  localparam logic [SLEN_W-1:0] FIXED_MIN_LEN = 16'd14;
  localparam logic [SLEN_W-1:0] DESC_MIN_LEN  = 16'd4;

  localparam logic [MODE_W-1:0] MODE_SENSE      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ_READY = 2'd1;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_TAG      = 3'd2,
    ERR_RESPONSE = 3'd3,
    ERR_UNIT_ID  = 3'd4
  } err_code_t;

  typedef struct packed {
    logic [BYTE_W-1:0] iu_byte;
    logic [SIZE_W-1:0] iu_size;
    logic [TAG_W-1:0]  cmd_tag;
    logic [MODE_W-1:0] mode;
    logic              last_byte;
  } item_t;

  // Unit state as it stands after the current byte has been captured
  typedef struct packed {
    logic [BYTE_W-1:0]              unit_id;
    logic [TAG_W-1:0]               unit_tag;
    logic [BYTE_W-1:0]              status_byte;
    logic [SLEN_W-1:0]              sense_len;
    logic [SENSE_N-1:0][BYTE_W-1:0] sense;
  } unit_view_t;

  typedef struct packed {
    logic              ok;
    err_code_t         error_code;
    logic [BYTE_W-1:0] dev_status;
    logic              sns_valid;
    logic [KEY_W-1:0]  sns_key;
    logic [BYTE_W-1:0] add_sense_code;
    logic [BYTE_W-1:0] add_sense_qualifier;
  } result_t;

endpackage

// File: src/usip_if.sv
// ----------------------------------------------------------------------------
// usip_if
// Valid/ready channels for status bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface usip_in_if;
  import usip_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] iu_byte;
  logic [SIZE_W-1:0] iu_size;
  logic [TAG_W-1:0]  cmd_tag;
  logic [MODE_W-1:0] mode;
  logic              last_byte;

  modport source (output valid, iu_byte, iu_size, cmd_tag, mode, last_byte,
                  input ready);
  modport sink   (input valid, iu_byte, iu_size, cmd_tag, mode, last_byte,
                  output ready);
endinterface

interface usip_out_if;
  import usip_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ERR_W-1:0]  error_code;
  logic [BYTE_W-1:0] dev_status;
  logic              sns_valid;
  logic [KEY_W-1:0]  sns_key;
  logic [BYTE_W-1:0] add_sense_code;
  logic [BYTE_W-1:0] add_sense_qualifier;

  modport source (output valid, ok, error_code, dev_status, sns_valid, sns_key,
                         add_sense_code, add_sense_qualifier,
                  input ready);
  modport sink   (input valid, ok, error_code, dev_status, sns_valid, sns_key,
                        add_sense_code, add_sense_qualifier,
                  output ready);
endinterface

// File: src/uas_status_iu_parser_unit.sv
// ----------------------------------------------------------------------------
// uas_status_iu_parser_unit
// Path: after the last byte's transaction the verdict passes the input
//   register, then the result register, before it is on out_ch.
// One byte per cycle unless out_ch stalls; capture/verdict is one register stage.
// Reset: synchronous rst_n clears the byte position, captured unit state and
//   both valid flags; no result is pending after reset.
// ----------------------------------------------------------------------------
module uas_status_iu_parser_unit
  import usip_pkg::*;
#(
  parameter int unsigned IU_MAX_BYTES = IU_MAX_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  usip_in_if.sink    in_ch,
  usip_out_if.source out_ch
);

  logic       s1_valid_r, s1_valid_nxt;
  item_t      s1_item_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  logic       advance;
  logic       step;
  logic       in_fire;
  unit_view_t view;
  logic [SIZE_W-1:0] size_c;
  result_t    res;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  usip_capture #(
    .IU_MAX_BYTES(IU_MAX_BYTES)
  ) u_capture (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (s1_item_r),
    .step   (step),
    .view   (view),
    .size_c (size_c)
  );

  usip_verdict u_verdict (
    .view    (view),
    .size_c  (size_c),
    .cmd_tag (s1_item_r.cmd_tag),
    .mode    (s1_item_r.mode),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)   s1_valid_nxt = 1'b1;
    else if (step) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = step && s1_item_r.last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.iu_byte   <= in_ch.iu_byte;
      s1_item_r.iu_size   <= in_ch.iu_size;
      s1_item_r.cmd_tag   <= in_ch.cmd_tag;
      s1_item_r.mode      <= in_ch.mode;
      s1_item_r.last_byte <= in_ch.last_byte;
    end
    if (step) out_res_r <= res;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.ok                  = out_res_r.ok;
  assign out_ch.error_code          = out_res_r.error_code;
  assign out_ch.dev_status          = out_res_r.dev_status;
  assign out_ch.sns_valid           = out_res_r.sns_valid;
  assign out_ch.sns_key             = out_res_r.sns_key;
  assign out_ch.add_sense_code      = out_res_r.add_sense_code;
  assign out_ch.add_sense_qualifier = out_res_r.add_sense_qualifier;

endmodule

// File: src/usip_capture.sv
// ----------------------------------------------------------------------------
// usip_capture
// Byte position tracking and capture of header fields and sense bytes.
// ----------------------------------------------------------------------------
module usip_capture
  import usip_pkg::*;
#(
  parameter int unsigned IU_MAX_BYTES = IU_MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  item_t             item,
  input  logic              step,
  output unit_view_t        view,
  output logic [SIZE_W-1:0] size_c
);

  localparam logic [SIZE_W-1:0] MAX_CLAMP =
    (IU_MAX_BYTES >= (1 << SIZE_W)) ? {SIZE_W{1'b1}} : SIZE_W'(IU_MAX_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  unit_view_t       view_r;
  unit_view_t       base_v;
  logic             longhdr;
  logic [POS_W-1:0] base_pos;
  logic [POS_W-1:0] len_pos;
  logic [POS_W-1:0] offs;
  logic [BYTE_W-1:0] b;

  assign b       = item.iu_byte;
  assign size_c  = (item.iu_size > MAX_CLAMP) ? MAX_CLAMP : item.iu_size;
  assign longhdr = (size_c >= SIZE_W'(16));
  assign base_pos = longhdr ? POS_W'(16) : POS_W'(8);
  assign len_pos  = longhdr ? POS_W'(14) : POS_W'(4);
  assign offs     = pos_r - base_pos;

  always_comb begin
    base_v = view_r;
    // first byte of a unit starts from a clean slate
    if (pos_r == '0) begin
      base_v         = '0;
      base_v.unit_id = b;
    end
    view = base_v;
    if (pos_r == POS_W'(2)) view.unit_tag[15:8] = b;
    if (pos_r == POS_W'(3)) view.unit_tag[7:0]  = b;
    if (pos_r == POS_W'(6)) view.status_byte    = b;
    if (pos_r == len_pos)            view.sense_len[15:8] = b;
    if (pos_r == len_pos + POS_W'(1)) view.sense_len[7:0] = b;
    if (pos_r >= base_pos) begin
      if (offs <= POS_W'(3))       view.sense[offs[1:0]] = b;
      else if (offs == POS_W'(12)) view.sense[4] = b;
      else if (offs == POS_W'(13)) view.sense[5] = b;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (item.last_byte)      pos_nxt = '0;
    else if (pos_r != POS_MAX) pos_nxt = pos_r + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      view_r <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      view_r <= view;
    end
  end

endmodule

// File: src/usip_verdict.sv
// ----------------------------------------------------------------------------
// usip_verdict
// Unit checks, sense length clamping and sense format decode.
// ----------------------------------------------------------------------------
module usip_verdict
  import usip_pkg::*;
(
  input  unit_view_t        view,
  input  logic [SIZE_W-1:0] size_c,
  input  logic [TAG_W-1:0]  cmd_tag,
  input  logic [MODE_W-1:0] mode,
  output result_t           res
);

  logic              longhdr;
  logic [SIZE_W-1:0] avail;
  logic [SLEN_W-1:0] len_adj;
  logic [SLEN_W-1:0] len;
  logic [6:0]        rc;
  logic [BYTE_W-1:0] want_id;
  logic              is_fixed;
  logic              is_desc;

  assign longhdr = (size_c >= SIZE_W'(16));
  assign avail   = longhdr ? size_c - SIZE_W'(16) : size_c - SIZE_W'(8);
  // old 8-byte header counts two extra bytes in its sense length
  assign len_adj = (!longhdr && view.sense_len >= SLEN_W'(2)) ?
                   view.sense_len - SLEN_W'(2) : view.sense_len;
  assign len     = (len_adj > SLEN_W'(avail)) ? SLEN_W'(avail) : len_adj;
  assign rc      = view.sense[0][6:0];
  assign is_fixed = (rc == RC_FIXED_CUR || rc == RC_FIXED_DEF) && len >= FIXED_MIN_LEN;
  assign is_desc  = (rc == RC_DESC_CUR || rc == RC_DESC_DEF) && len >= DESC_MIN_LEN;
  assign want_id  = (mode == MODE_READ_READY) ? IU_ID_READ_READY : IU_ID_WRITE_READY;

  always_comb begin
    res = '0;
    res.error_code = ERR_NONE;
    priority if (size_c < SIZE_W'(4)) begin
      res.error_code = ERR_SHORT;
    end else if (view.unit_tag != cmd_tag) begin
      res.error_code = ERR_TAG;
    end else if (mode != MODE_SENSE) begin
      if (view.unit_id == want_id) res.ok = 1'b1;
      else                         res.error_code = ERR_UNIT_ID;
    end else if (view.unit_id == IU_ID_RESPONSE) begin
      res.error_code = ERR_RESPONSE;
    end else if (view.unit_id != IU_ID_SENSE) begin
      res.error_code = ERR_UNIT_ID;
    end else if (size_c < SIZE_W'(8)) begin
      res.error_code = ERR_SHORT;
    end else begin
      res.ok         = 1'b1;
      res.dev_status = view.status_byte;
      if (len != '0) begin
        if (is_fixed) begin
          res.sns_valid           = 1'b1;
          res.sns_key             = view.sense[2][KEY_W-1:0];
          res.add_sense_code      = view.sense[4];
          res.add_sense_qualifier = view.sense[5];
        end else if (is_desc) begin
          res.sns_valid           = 1'b1;
          res.sns_key             = view.sense[1][KEY_W-1:0];
          res.add_sense_code      = view.sense[2];
          res.add_sense_qualifier = view.sense[3];
        end
      end
    end
  end

endmodule

// File: src/usip_checker.sv
// ----------------------------------------------------------------------------
// usip_checker
// Port-level checks on the verdict channel of the status IU parser.
// ----------------------------------------------------------------------------
module usip_checker
  import usip_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              ok,
  input logic [ERR_W-1:0]  error_code,
  input logic [BYTE_W-1:0] dev_status,
  input logic              sns_valid,
  input logic [KEY_W-1:0]  sns_key,
  input logic [BYTE_W-1:0] add_sense_code,
  input logic [BYTE_W-1:0] add_sense_qualifier
);

  // a pending transaction is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict pending after reset");

  a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ok |-> error_code == ERR_NONE)
    else $error("accepted unit carries an error code");

  // failed units report a reason and nothing else
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !ok |-> error_code != ERR_NONE && dev_status == '0 &&
      !sns_valid && sns_key == '0 && add_sense_code == '0 &&
      add_sense_qualifier == '0)
    else $error("failed unit carries sense fields");

  a_sense_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !sns_valid |-> sns_key == '0 && add_sense_code == '0 &&
      add_sense_qualifier == '0)
    else $error("sense fields set without decoded sense");

endmodule

bind uas_status_iu_parser_unit usip_checker u_usip_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .ok                  (out_ch.ok),
  .error_code          (out_ch.error_code),
  .dev_status          (out_ch.dev_status),
  .sns_valid           (out_ch.sns_valid),
  .sns_key             (out_ch.sns_key),
  .add_sense_code      (out_ch.add_sense_code),
  .add_sense_qualifier (out_ch.add_sense_qualifier)
);

// File: sim/uas_status_iu_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_status_iu_parser_unit_tb
// Drives status IUs, whole or in part, into the parser one byte per transaction and
// checks every verdict against an in-bench model of the byte capture and decode, or
// the row's own verdict for typed rows. A short hand-built table comes first; random
// units follow in four idle/stall phases, with one long receiver hold and one long unit.
// ----------------------------------------------------------------------------
module uas_status_iu_parser_unit_tb;
  import usip_pkg::*;

  localparam int unsigned IU_MAX       = IU_MAX_BYTES_DEF;
  localparam int unsigned HDR_LONG     = 16;  // r02 header length
  localparam int unsigned HDR_OLD      = 8;   // pre-r02 header length
  localparam int unsigned LEN_AT_LONG  = 14;
  localparam int unsigned LEN_AT_OLD   = 4;
  localparam int unsigned OLD_LEN_BIAS = 2;
  localparam int unsigned MIN_IU       = 4;
  localparam int unsigned ASC_OFS      = 12;
  localparam int unsigned ASCQ_OFS     = 13;
  localparam int unsigned PHASE_ITEMS  = 280;
  localparam int unsigned LONG_BYTES   = 200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [MODE_W-1:0] MODE_WRITE_READY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE       = 2'd3;

  localparam logic [1:0] FLAW_NONE     = 2'd0;
  localparam logic [1:0] FLAW_NO_LAST  = 2'd1;
  localparam logic [1:0] FLAW_SIZE_MIX = 2'd2;

  // one status IU as the sender builds it
  typedef struct {
    logic [BYTE_W-1:0]              uid;
    logic [TAG_W-1:0]               tag;
    logic [TAG_W-1:0]               etag;
    logic [MODE_W-1:0]              mode;
    logic [BYTE_W-1:0]              status;
    logic [SLEN_W-1:0]              slen;
    logic [SENSE_N-1:0][BYTE_W-1:0] sns;   // sense bytes 0,1,2,3,12,13
    int                             size;
    int                             nbytes;
    logic [1:0]                     flaw;
    bit                             typed;
    result_t                        texp;
  } iu_desc_t;

  logic clk = 1'b0;
  logic rst_n;

  usip_in_if  in_ch ();
  usip_out_if out_ch ();

  uas_status_iu_parser_unit #(
    .IU_MAX_BYTES(IU_MAX)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser model state
  logic [POS_W-1:0]               cur_pos;
  logic [BYTE_W-1:0]              cur_id;
  logic [TAG_W-1:0]               cur_tag;
  logic [BYTE_W-1:0]              cur_status;
  logic [SLEN_W-1:0]              cur_slen;
  logic [SENSE_N-1:0][BYTE_W-1:0] cur_sense;

  result_t     verdict_q[$];
  iu_desc_t    dir_rows[$];
  int unsigned n_bad;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  function automatic logic [SENSE_N-1:0][BYTE_W-1:0] sense6(
    logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
    logic [7:0] b3, logic [7:0] b12, logic [7:0] b13);
    return {b13, b12, b3, b2, b1, b0};
  endfunction

  function automatic result_t fail_res(err_code_t e);
    result_t r;
    r = '0;
    r.error_code = e;
    return r;
  endfunction

  function automatic result_t ok_res();
    result_t r;
    r = '0;
    r.ok = 1'b1;
    return r;
  endfunction

  // Capture one byte into the model state; at the last byte give the verdict.
  task automatic parse_byte(input item_t it, output bit got, output result_t r);
    int unsigned sz, p, base, lenpos, o, len, avail;
    bit          longhdr;
    logic [6:0]  rc;
    logic [7:0]  want;
    sz      = (it.iu_size > IU_MAX) ? IU_MAX : it.iu_size;
    longhdr = (sz >= HDR_LONG);
    base    = longhdr ? HDR_LONG : HDR_OLD;
    lenpos  = longhdr ? LEN_AT_LONG : LEN_AT_OLD;
    p       = cur_pos;
    got     = 1'b0;
    r       = '0;
    if (p == 0) begin
      cur_tag    = '0;
      cur_status = '0;
      cur_slen   = '0;
      cur_sense  = '0;
      cur_id     = it.iu_byte;
    end
    if (p == 2) cur_tag[15:8] = it.iu_byte;
    if (p == 3) cur_tag[7:0] = it.iu_byte;
    if (p == 6) cur_status = it.iu_byte;
    if (p == lenpos) cur_slen[15:8] = it.iu_byte;
    if (p == lenpos + 1) cur_slen[7:0] = it.iu_byte;
    if (p >= base) begin
      o = p - base;
      if (o <= 3) cur_sense[o] = it.iu_byte;
      else if (o == ASC_OFS) cur_sense[4] = it.iu_byte;
      else if (o == ASCQ_OFS) cur_sense[5] = it.iu_byte;
    end
    if (p < POS_MAX) cur_pos = POS_W'(p + 1);
    if (it.last_byte) begin
      got     = 1'b1;
      cur_pos = '0;
      if (sz < MIN_IU) begin
        r.error_code = ERR_SHORT;
      end else if (cur_tag != it.cmd_tag) begin
        r.error_code = ERR_TAG;
      end else if (it.mode != MODE_SENSE) begin
        want = (it.mode == MODE_READ_READY) ? IU_ID_READ_READY : IU_ID_WRITE_READY;
        if (cur_id != want) r.error_code = ERR_UNIT_ID;
        else r.ok = 1'b1;
      end else if (cur_id == IU_ID_RESPONSE) begin
        r.error_code = ERR_RESPONSE;
      end else if (cur_id != IU_ID_SENSE) begin
        r.error_code = ERR_UNIT_ID;
      end else if (sz < HDR_OLD) begin
        r.error_code = ERR_SHORT;
      end else begin
        r.ok         = 1'b1;
        r.dev_status = cur_status;
        len          = cur_slen;
        if (longhdr) begin
          avail = sz - HDR_LONG;
        end else begin
          // old header counts the two length bytes in the sense length
          if (len >= OLD_LEN_BIAS) len = len - OLD_LEN_BIAS;
          avail = sz - HDR_OLD;
        end
        if (len > avail) len = avail;
        rc = cur_sense[0][6:0];
        if (len != 0) begin
          if ((rc == RC_FIXED_CUR || rc == RC_FIXED_DEF) && len >= FIXED_MIN_LEN) begin
            r.sns_valid           = 1'b1;
            r.sns_key             = cur_sense[2][3:0];
            r.add_sense_code      = cur_sense[4];
            r.add_sense_qualifier = cur_sense[5];
          end else if ((rc == RC_DESC_CUR || rc == RC_DESC_DEF) && len >= DESC_MIN_LEN) begin
            r.sns_valid           = 1'b1;
            r.sns_key             = cur_sense[1][3:0];
            r.add_sense_code      = cur_sense[2];
            r.add_sense_qualifier = cur_sense[3];
          end
        end
      end
    end
  endtask

  function automatic logic [7:0] iu_byte_at(iu_desc_t d, int p);
    int base, lenpos;
    base   = (d.size >= HDR_LONG) ? HDR_LONG : HDR_OLD;
    lenpos = (d.size >= HDR_LONG) ? LEN_AT_LONG : LEN_AT_OLD;
    if (p == 0) return d.uid;
    if (p == 2) return d.tag[15:8];
    if (p == 3) return d.tag[7:0];
    if (p == 6) return d.status;
    if (p == lenpos) return d.slen[15:8];
    if (p == lenpos + 1) return d.slen[7:0];
    if (p >= base && p - base <= 3) return d.sns[p - base];
    if (p - base == ASC_OFS) return d.sns[4];
    if (p - base == ASCQ_OFS) return d.sns[5];
    return 8'($urandom_range(255));
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom_range(7);
    if (r < 30) return $urandom_range(8, 15);
    if (r < 75) return $urandom_range(16, 40);
    if (r < 93) return $urandom_range(41, 300);
    return $urandom_range(301, 8191);
  endfunction

  function automatic logic [7:0] pick_id();
    case ($urandom_range(4))
      0:       return IU_ID_SENSE;
      1:       return IU_ID_RESPONSE;
      2:       return IU_ID_READ_READY;
      3:       return IU_ID_WRITE_READY;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed sense or ready units with random content, rest noise.
  function automatic iu_desc_t rand_iu();
    iu_desc_t   d;
    int         k, r, hdr, want;
    logic [6:0] rc;
    k      = $urandom_range(99);
    d.tag  = 16'($urandom_range(16'hFFFF));
    d.etag = ($urandom_range(19) == 0) ? 16'($urandom_range(16'hFFFF)) : d.tag;
    d.status = 8'($urandom_range(255));
    for (int i = 0; i < SENSE_N; i++) d.sns[i] = 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       rc = RC_FIXED_CUR;
      1:       rc = RC_FIXED_DEF;
      2:       rc = RC_DESC_CUR;
      default: rc = RC_DESC_DEF;
    endcase
    if ($urandom_range(4) != 0) d.sns[0] = {1'($urandom_range(1)), rc};
    d.flaw  = FLAW_NONE;
    d.typed = 1'b0;
    d.texp  = '0;
    if (k < 55) begin
      d.uid  = IU_ID_SENSE;
      d.mode = MODE_SENSE;
      r = $urandom_range(99);
      if (r < 15) d.size = $urandom_range(4, 15);
      else if (r < 35) d.size = $urandom_range(16, 19);
      else if (r < 70) d.size = $urandom_range(28, 32);   // around the fixed-format minimum
      else if (r < 90) d.size = $urandom_range(16, 64);
      else d.size = pick_size();
    end else if (k < 80) begin
      d.mode = MODE_W'($urandom_range(1, 3));
      if ($urandom_range(4) != 0)
        d.uid = (d.mode == MODE_READ_READY) ? IU_ID_READ_READY : IU_ID_WRITE_READY;
      else
        d.uid = pick_id();
      d.size = ($urandom_range(9) != 0) ? $urandom_range(4, 20) : pick_size();
    end else begin
      d.uid  = pick_id();
      d.mode = MODE_W'($urandom_range(3));
      d.size = pick_size();
      r = $urandom_range(9);
      if (r == 0) d.flaw = FLAW_NO_LAST;
      else if (r == 1) d.flaw = FLAW_SIZE_MIX;
    end
    d.nbytes = (d.size > 300) ? $urandom_range(24, 80) : d.size;
    if (k >= 80 && $urandom_range(1) == 0) d.nbytes = $urandom_range(1, 48);
    if (d.nbytes < 1) d.nbytes = 1;
    hdr  = (d.size >= HDR_LONG) ? HDR_LONG : HDR_OLD;
    want = (d.size > hdr) ? d.size - hdr : 0;
    if (d.size < HDR_LONG) want = want + OLD_LEN_BIAS;
    r = $urandom_range(99);
    if (r < 60) begin
      want = want + $urandom_range(4) - 2;
      d.slen = (want < 0) ? '0 : SLEN_W'(want);
    end else if (r < 70) begin
      d.slen = '0;
    end else if (r < 78) begin
      d.slen = SLEN_W'($urandom_range(1, 3));
    end else if (r < 88) begin
      d.slen = '1;
    end else begin
      d.slen = SLEN_W'($urandom_range(16'hFFFF));
    end
    return d;
  endfunction

  // One byte transaction; the verdict it causes goes into verdict_q.
  task automatic send_byte(input item_t it, input bit typed, input result_t texp);
    bit      got;
    result_t pred;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.iu_byte   <= it.iu_byte;
    in_ch.iu_size   <= it.iu_size;
    in_ch.cmd_tag   <= it.cmd_tag;
    in_ch.mode      <= it.mode;
    in_ch.last_byte <= it.last_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_byte(it, got, pred);
    if (got) verdict_q.push_back(typed ? texp : pred);
  endtask

  task automatic send_iu(iu_desc_t d);
    item_t it;
    for (int p = 0; p < d.nbytes; p++) begin
      it.iu_byte = iu_byte_at(d, p);
      if (d.flaw == FLAW_SIZE_MIX)
        it.iu_size = ($urandom_range(1) != 0) ? SIZE_W'($urandom_range(40))
                                              : SIZE_W'($urandom_range(8191));
      else
        it.iu_size = SIZE_W'(d.size);
      it.cmd_tag   = d.etag;
      it.mode      = d.mode;
      it.last_byte = (p == d.nbytes - 1) && (d.flaw != FLAW_NO_LAST);
      send_byte(it, d.typed, d.texp);
    end
    items_sent += d.nbytes;
  endtask

  // sender stays quiet until every pending verdict has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_verdict();
    result_t want;
    bit      bad;
    if (verdict_q.size() == 0) begin
      n_bad++;
      if (n_bad <= MAX_REPORTS)
        $display("verdict with none pending: ok=%0d err=%0d st=%02h sv=%0d",
                 out_ch.ok, out_ch.error_code, out_ch.dev_status, out_ch.sns_valid);
    end else begin
      want = verdict_q.pop_front();
      bad  = (want.ok !== out_ch.ok) || (want.error_code !== out_ch.error_code) ||
             (want.dev_status !== out_ch.dev_status) ||
             (want.sns_valid !== out_ch.sns_valid) ||
             (want.sns_key !== out_ch.sns_key) ||
             (want.add_sense_code !== out_ch.add_sense_code) ||
             (want.add_sense_qualifier !== out_ch.add_sense_qualifier);
      if (bad) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS) begin
          $display("verdict mismatch");
          $display("  exp ok=%0d err=%0d st=%02h sv=%0d key=%0h asc=%02h ascq=%02h",
                   want.ok, want.error_code, want.dev_status, want.sns_valid,
                   want.sns_key, want.add_sense_code, want.add_sense_qualifier);
          $display("  got ok=%0d err=%0d st=%02h sv=%0d key=%0h asc=%02h ascq=%02h",
                   out_ch.ok, out_ch.error_code, out_ch.dev_status, out_ch.sns_valid,
                   out_ch.sns_key, out_ch.add_sense_code, out_ch.add_sense_qualifier);
        end
      end
    end
  endtask

  // receiver: check each verdict transaction, then choose next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      n_bad     = 0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_verdict();
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("uas_status_iu_parser_unit_tb: errors");
    $finish;
  end

  initial begin
    iu_desc_t    d;
    int unsigned phase_start;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.iu_byte   = '0;
    in_ch.iu_size   = '0;
    in_ch.cmd_tag   = '0;
    in_ch.mode      = MODE_SENSE;
    in_ch.last_byte = 1'b0;
    cur_pos = '0; cur_id = '0; cur_tag = '0; cur_status = '0; cur_slen = '0; cur_sense = '0;
    items_sent = 0; send_idle_pct = 0; recv_stall_pct = 0;
    hold_req = 0;

    // uid, tag, etag, mode, status, slen, sense, size, nbytes, flaw, typed, verdict
    dir_rows.push_back('{8'hFF, 16'hFFFF, 16'h0000, MODE_SENSE, 8'hFF, 16'hFFFF,
                         sense6(0, 0, 0, 0, 0, 0), 1, 1, FLAW_NONE, 1'b1, fail_res(ERR_SHORT)});
    dir_rows.push_back('{IU_ID_READ_READY, 16'h1234, 16'h1234, MODE_READ_READY, 8'h00, 16'h0,
                         sense6(0, 0, 0, 0, 0, 0), 4, 4, FLAW_NONE, 1'b1, ok_res()});
    dir_rows.push_back('{IU_ID_WRITE_READY, 16'hABCD, 16'hABCE, MODE_WRITE_READY, 8'h00, 16'h0,
                         sense6(0, 0, 0, 0, 0, 0), 4, 4, FLAW_NONE, 1'b1, fail_res(ERR_TAG)});
    dir_rows.push_back('{IU_ID_WRITE_READY, 16'hFFFF, 16'hFFFF, MODE_SPARE, 8'h00, 16'h0,
                         sense6(0, 0, 0, 0, 0, 0), 4, 4, FLAW_NONE, 1'b0, '0});
    dir_rows.push_back('{IU_ID_READ_READY, 16'h0000, 16'h0000, MODE_WRITE_READY, 8'h00, 16'h0,
                         sense6(0, 0, 0, 0, 0, 0), 4, 4, FLAW_NONE, 1'b1, fail_res(ERR_UNIT_ID)});
    dir_rows.push_back('{IU_ID_RESPONSE, 16'h0001, 16'h0001, MODE_SENSE, 8'h00, 16'h0,
                         sense6(0, 0, 0, 0, 0, 0), 4, 4, FLAW_NONE, 1'b1, fail_res(ERR_RESPONSE)});
    dir_rows.push_back('{IU_ID_RESPONSE, 16'h8000, 16'h0000, MODE_SENSE, 8'h00, 16'h0,
                         sense6(0, 0, 0, 0, 0, 0), 4, 4, FLAW_NONE, 1'b1, fail_res(ERR_TAG)});
    dir_rows.push_back('{8'hFF, 16'h00FF, 16'h00FF, MODE_SENSE, 8'h00, 16'h0,
                         sense6(0, 0, 0, 0, 0, 0), 4, 4, FLAW_NONE, 1'b1, fail_res(ERR_UNIT_ID)});
    dir_rows.push_back('{IU_ID_SENSE, 16'h5555, 16'h5555, MODE_SENSE, 8'h02, 16'h0,
                         sense6(0, 0, 0, 0, 0, 0), 7, 7, FLAW_NONE, 1'b1, fail_res(ERR_SHORT)});
    // old header, no room for sense
    dir_rows.push_back('{IU_ID_SENSE, 16'hAAAA, 16'hAAAA, MODE_SENSE, 8'h00, 16'h0002,
                         sense6(0, 0, 0, 0, 0, 0), 8, 8, FLAW_NONE, 1'b0, '0});
    // old header, descriptor sense
    dir_rows.push_back('{IU_ID_SENSE, 16'h0102, 16'h0102, MODE_SENSE, 8'h02, 16'h0006,
                         sense6(8'h72, 8'h05, 8'h24, 8'h00, 0, 0), 12, 12, FLAW_NONE, 1'b0, '0});
    // r02 header, fixed sense, exactly the minimum and one short of it
    dir_rows.push_back('{IU_ID_SENSE, 16'h0F0F, 16'h0F0F, MODE_SENSE, 8'h02, 16'd14,
                         sense6(8'h70, 8'h00, 8'h06, 8'h00, 8'h29, 8'h07), 30, 30,
                         FLAW_NONE, 1'b0, '0});
    dir_rows.push_back('{IU_ID_SENSE, 16'h0F0F, 16'h0F0F, MODE_SENSE, 8'h02, 16'd13,
                         sense6(8'h70, 8'h00, 8'h06, 8'h00, 8'h29, 8'h07), 30, 30,
                         FLAW_NONE, 1'b0, '0});
    // deferred descriptor with bit 7 set
    dir_rows.push_back('{IU_ID_SENSE, 16'h7E7E, 16'h7E7E, MODE_SENSE, 8'hFF, 16'd4,
                         sense6(8'hF3, 8'h0B, 8'hFF, 8'hFF, 0, 0), 20, 20, FLAW_NONE, 1'b0, '0});
    // sense length far beyond what arrived
    dir_rows.push_back('{IU_ID_SENSE, 16'h2468, 16'h2468, MODE_SENSE, 8'h08, 16'hFFFF,
                         sense6(8'hF1, 8'h00, 8'h0F, 8'h00, 8'hFF, 8'hFF), 40, 40,
                         FLAW_NONE, 1'b0, '0});
    // fewer bytes than the size says
    dir_rows.push_back('{IU_ID_SENSE, 16'h1357, 16'h1357, MODE_SENSE, 8'h02, 16'd14,
                         sense6(8'h70, 8'h00, 8'h03, 8'h00, 8'h11, 8'h22), 30, 22,
                         FLAW_NONE, 1'b0, '0});
    // more bytes than the size says
    dir_rows.push_back('{IU_ID_SENSE, 16'h9999, 16'h9999, MODE_SENSE, 8'h02, 16'h0006,
                         sense6(8'h72, 8'h04, 8'h44, 8'h01, 0, 0), 12, 40, FLAW_NONE, 1'b0, '0});
    // size field at its top, clamped
    dir_rows.push_back('{IU_ID_SENSE, 16'h4321, 16'h4321, MODE_SENSE, 8'h22, 16'd100,
                         sense6(8'h70, 8'h00, 8'h05, 8'h00, 8'h20, 8'h00), 8191, 30,
                         FLAW_NONE, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_iu(dir_rows[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 0) begin
        // full-size unit with only its leading part sent
        d = rand_iu();
        d.uid = IU_ID_SENSE; d.mode = MODE_SENSE; d.etag = d.tag; d.flaw = FLAW_NONE;
        d.slen = '1; d.size = IU_MAX; d.nbytes = LONG_BYTES;
        d.sns[0] = {1'b0, RC_FIXED_CUR};
        send_iu(d);
      end
      if (ph == 2) begin
        // receiver holds off while small units keep coming
        hold_req++;
        for (int j = 0; j < 40; j++) begin
          d = rand_iu();
          d.uid = IU_ID_READ_READY; d.mode = MODE_READ_READY; d.etag = d.tag;
          d.size = MIN_IU; d.nbytes = MIN_IU; d.flaw = FLAW_NONE;
          send_iu(d);
        end
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_iu(rand_iu());
      drain();
    end

    recv_stall_pct = 0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_bad == 0 && verdict_q.size() == 0) begin
      $display("uas_status_iu_parser_unit_tb: clean");
    end else begin
      $display("uas_status_iu_parser_unit_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/usip_pkg.sv
src/usip_if.sv
src/usip_capture.sv
src/usip_verdict.sv
src/uas_status_iu_parser_unit.sv
src/usip_checker.sv
sim/uas_status_iu_parser_unit_tb.sv
